// ----- hw/rtl/sts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

  localparam int TS_W          = 63;
  localparam int IDX_W         = 10;
  localparam int USED_W        = 11;
  localparam int DEPTH_DEFAULT = 1024;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] entry_index;
    logic [TS_W-1:0]  timestamp;
    logic             exact_match;
  } sts_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic             found;
  } sts_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_CMP,
    ST_FINAL
  } sts_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sts_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sts_ram #(
  parameter int WIDTH = sts_pkg::TS_W,
  parameter int DEPTH = sts_pkg::DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_timestamp_seek_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Lower-bound search over a table of ascending timestamps held in one
// single-read-port RAM. A load beat writes one entry in the cycle it is
// accepted and leaves busy low. A query beat on a non-empty table raises busy
// and reads entry 0, then the last valid entry, then one probe per halving of
// the range, then the candidate. out_valid rises in the same cycle that busy
// drops, so the next beat can be taken in that cycle. Each step waits on the
// registered read of the RAM. A query against an empty table or outside the
// stored span returns not-found early. The result sits on out_data for the
// single cycle that out_valid is high; the receiver cannot hold it off, so it
// must take it then. entries_used may only be rewritten while busy is low.

module sorted_timestamp_seek_unit #(
  parameter int TABLE_DEPTH = sts_pkg::DEPTH_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire sts_pkg::sts_in_t        in_data,
  output logic                         out_valid,
  output sts_pkg::sts_out_t            out_data,
  input  wire logic                    cfg_we,
  input  wire logic [sts_pkg::USED_W-1:0] cfg_wdata
);

  import sts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = AW + 1;
  localparam int CW = (NW > USED_W) ? NW : USED_W;
  localparam int LW = (NW > IDX_W) ? NW : IDX_W;

  function automatic logic [AW-1:0] mid_of(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[AW:1];
  endfunction

  sts_state_t        state_r, state_nxt;
  logic [USED_W-1:0] entries_used_r;
  logic [AW-1:0]     lo_r, lo_nxt;
  logic [AW-1:0]     hi_r, hi_nxt;
  logic [AW-1:0]     mid_r, mid_nxt;
  logic [TS_W-1:0]   ts_r, ts_nxt;
  logic              exact_r, exact_nxt;
  logic              out_valid_r, out_valid_nxt;
  sts_out_t          out_data_r, out_data_nxt;

  logic [CW-1:0]     used_ext;
  logic [CW-1:0]     n_full;
  logic [NW-1:0]     n_valid;
  logic              accept;
  logic              load_ok;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [TS_W-1:0]   ram_rdata;
  logic [AW-1:0]     lo_step, hi_step;
  logic              cand_hit;

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);

  // The count saturates at the table depth.
  assign used_ext = CW'(entries_used_r);
  assign n_full   = (used_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : used_ext;
  assign n_valid  = NW'(n_full);

  assign load_ok   = LW'(in_data.entry_index) < LW'(TABLE_DEPTH);
  assign ram_we    = accept && (in_data.mode == MODE_LOAD) && load_ok;
  assign ram_waddr = AW'(in_data.entry_index);

  // Narrowing step on the entry read at mid_r.
  assign lo_step  = (ram_rdata < ts_r) ? (mid_r + AW'(1)) : lo_r;
  assign hi_step  = (ram_rdata < ts_r) ? hi_r : mid_r;
  assign cand_hit = exact_r ? (ram_rdata == ts_r) : (ram_rdata >= ts_r);

  sts_ram #(
    .WIDTH(TS_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_data.timestamp),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    ts_nxt        = ts_r;
    exact_nxt     = exact_r;
    ram_raddr     = '0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.mode == MODE_QUERY)) begin
          ts_nxt    = in_data.timestamp;
          exact_nxt = in_data.exact_match;
          lo_nxt    = '0;
          hi_nxt    = AW'(n_valid - NW'(1));
          if (n_valid == '0) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{result_index: '0, found: 1'b0};
          end else begin
            state_nxt = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        if (ts_r < ram_rdata) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{result_index: '0, found: 1'b0};
          state_nxt     = ST_IDLE;
        end else begin
          ram_raddr = hi_r;
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        if (ts_r > ram_rdata) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{result_index: '0, found: 1'b0};
          state_nxt     = ST_IDLE;
        end else if (lo_r < hi_r) begin
          mid_nxt   = mid_of(lo_r, hi_r);
          ram_raddr = mid_of(lo_r, hi_r);
          state_nxt = ST_CMP;
        end else begin
          ram_raddr = lo_r;
          state_nxt = ST_FINAL;
        end
      end
      ST_CMP: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
        if (lo_step < hi_step) begin
          mid_nxt   = mid_of(lo_step, hi_step);
          ram_raddr = mid_of(lo_step, hi_step);
        end else begin
          ram_raddr = lo_step;
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{result_index: cand_hit ? IDX_W'(lo_r) : '0, found: cand_hit};
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      entries_used_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        entries_used_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    ts_r       <= ts_nxt;
    exact_r    <= exact_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- sim/sorted_timestamp_seek_unit_tb.sv -----
`timescale 1ns / 1ps

module sorted_timestamp_seek_unit_tb;
  import sts_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 24;
  localparam logic [TS_W-1:0] TS_MAX = '1;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  sts_in_t in_data;
  logic out_valid;
  sts_out_t out_data;
  logic cfg_we;
  logic [USED_W-1:0] cfg_wdata;

  // Shadow copy of the block's table and count register.
  logic [TS_W-1:0] ts_table [DEPTH];
  logic [USED_W-1:0] used_reg;
  sts_out_t answer_q [$];

  bit gaps_on;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned loads_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned answers_seen = 0;
  int unsigned cfg_writes = 0;

  sorted_timestamp_seek_unit #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d searches outstanding",
               answer_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    sts_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      answers_seen++;
      if (answer_q.size() == 0) begin
        flag_mismatch($sformatf("result index %0d found %0b with no search pending",
                                out_data.result_index, out_data.found));
      end else begin
        want = answer_q.pop_front();
        if (out_data.result_index !== want.result_index)
          flag_mismatch($sformatf("result_index %0d, expected %0d",
                                  out_data.result_index, want.result_index));
        if (out_data.found !== want.found)
          flag_mismatch($sformatf("found %0b, expected %0b", out_data.found, want.found));
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned live_entries();
    return (used_reg > DEPTH) ? DEPTH : used_reg;
  endfunction

  // Lower-bound search over the shadow table, bounded by the span check.
  function automatic sts_out_t seek_expected(input logic [TS_W-1:0] t, input logic exact);
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    sts_out_t r;
    n = live_entries();
    r = '0;
    lo = 0;
    if (n != 0 && t >= ts_table[0] && t <= ts_table[n-1]) begin
      hi = n - 1;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (ts_table[mid] < t)
          lo = mid + 1;
        else
          hi = mid;
      end
      if (exact ? (ts_table[lo] == t) : (ts_table[lo] >= t)) begin
        r.result_index = lo[IDX_W-1:0];
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

  // Start stays high after a beat so that back-to-back beats need no toggle.
  task automatic send_beat(input logic mode, input logic [IDX_W-1:0] idx,
                           input logic [TS_W-1:0] ts, input logic exact);
    sts_in_t beat;
    beat.mode = mode;
    beat.entry_index = idx;
    beat.timestamp = ts;
    beat.exact_match = exact;
    if (gaps_on && $urandom_range(99) < 23) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 23);
    end
    start <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (busy);
    if (mode == MODE_LOAD) begin
      ts_table[idx] = ts;
      loads_sent++;
    end else begin
      answer_q = {answer_q, seek_expected(ts, exact)};
      queries_sent++;
    end
  endtask

  task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [TS_W-1:0] ts);
    send_beat(MODE_LOAD, idx, ts, 1'($urandom_range(1)));
  endtask

  task automatic query_time(input logic [TS_W-1:0] ts, input logic exact);
    send_beat(MODE_QUERY, IDX_W'($urandom), ts, exact);
  endtask

  // Loads never produce a result, so the settle time covers one still in flight.
  task automatic wait_quiet();
    start <= 1'b0;
    while (answer_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_entries_used(input logic [USED_W-1:0] value);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    used_reg = value;
    cfg_writes++;
    cfg_we <= 1'b0;
  endtask

  // Ascending, distinct values spaced about 2**shift apart at a random base.
  task automatic load_sorted(input int unsigned count, input int unsigned shift);
    logic [63:0] span;
    logic [63:0] base;
    logic [63:0] jitter_mask;
    span = 64'(count + 1) << shift;
    jitter_mask = (64'h1 << shift) - 1;
    base = rand64() % ((64'h1 << 62) - span);
    for (int unsigned i = 0; i < count; i++)
      load_entry(IDX_W'(i), TS_W'(base + (64'(i) << shift) + (rand64() & jitter_mask)));
  endtask

  function automatic logic [TS_W-1:0] pick_seek_time(input int unsigned n);
    int unsigned j;
    logic [TS_W-1:0] t;
    t = TS_W'(rand64());
    if (n != 0) begin
      j = $urandom_range(n - 1);
      case ($urandom_range(9))
        0, 1, 2, 3: t = ts_table[j];
        4: t = ts_table[j] + 1'b1;
        5: t = ts_table[j] - 1'b1;
        6: t = (ts_table[0] == '0) ? '0 : TS_W'(rand64()) % ts_table[0];
        7: t = ts_table[n-1] + TS_W'($urandom_range(1, 1000));
        9: t = $urandom_range(1) ? TS_MAX : '0;
        default: ;
      endcase
    end
    return t;
  endfunction

  // Searches with a share of stray loads to random positions mixed in.
  task automatic seek_burst(input int unsigned count, input int unsigned noise_pct);
    repeat (count) begin
      if ($urandom_range(99) < noise_pct)
        load_entry(IDX_W'($urandom), TS_W'(rand64()));
      else
        query_time(pick_seek_time(live_entries()), 1'($urandom_range(1)));
    end
  endtask

  // Entry 0 is written first so that nothing unwritten is ever probed.
  task automatic test_empty_table();
    load_entry('0, TS_W'(5));
    query_time(TS_W'(5), 1'b1);
    query_time(TS_W'(5), 1'b0);
  endtask

  task automatic test_single_entry();
    set_entries_used(USED_W'(1));
    query_time(TS_W'(5), 1'b1);
    query_time(TS_W'(5), 1'b0);
    query_time(TS_W'(4), 1'b0);
    query_time(TS_W'(6), 1'b0);
  endtask

  task automatic test_small_table();
    load_entry(IDX_W'(0), '0);
    load_entry(IDX_W'(1), TS_W'(100));
    load_entry(IDX_W'(2), TS_W'(200));
    load_entry(IDX_W'(3), TS_MAX);
    set_entries_used(USED_W'(4));
    query_time('0, 1'b1);
    query_time(TS_MAX, 1'b1);
    query_time(TS_MAX, 1'b0);
    query_time(TS_W'(150), 1'b1);
    query_time(TS_W'(150), 1'b0);
    query_time(TS_W'(100), 1'b0);
    query_time(TS_W'(99), 1'b0);
    query_time(TS_W'(101), 1'b1);
  endtask

  // The full load runs without gaps; counts above the depth must saturate.
  task automatic test_full_table();
    gaps_on = 1'b0;
    for (int i = 0; i < DEPTH; i++)
      load_entry(IDX_W'(i), (i == DEPTH - 1) ? TS_MAX : {i[IDX_W-1:0], 53'(rand64())});
    set_entries_used(USED_W'(DEPTH));
    seek_burst(40, 0);
    gaps_on = 1'b1;
    set_entries_used('1);
    seek_burst(40, 0);
    set_entries_used(USED_W'($urandom_range(DEPTH + 1, 2046)));
    seek_burst(40, 0);
  endtask

  task automatic test_sorted_rounds();
    int unsigned n;
    for (int r = 0; r < 8; r++) begin
      n = (r == 0) ? 0 : (r == 1) ? 2 : $urandom_range(1, 40);
      load_sorted(n, $urandom_range(0, 52));
      set_entries_used(USED_W'(n));
      seek_burst(30, 10);
    end
  endtask

  // Random order with repeated values; the search must still follow its probes.
  task automatic test_unordered_table();
    int unsigned n;
    repeat (2) begin
      n = $urandom_range(5, 40);
      for (int unsigned i = 0; i < n; i++)
        load_entry(IDX_W'(i), (i > 0 && $urandom_range(4) == 0) ? ts_table[i-1]
                                                                : TS_W'(rand64()));
      set_entries_used(USED_W'(n));
      seek_burst(40, 0);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    used_reg = '0;
    gaps_on = 1'b1;
    foreach (ts_table[i]) ts_table[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_single_entry();
    test_small_table();
    test_full_table();
    test_sorted_rounds();
    test_unordered_table();

    wait_quiet();
    $display("Ran %0d table loads and %0d searches, checked %0d results, %0d register writes.",
             loads_sent, queries_sent, answers_seen, cfg_writes);
    $display("Tables ranged from empty through full and saturated, sorted and unsorted.");
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
